// ----- hdl/fmv_pkg.sv -----
package fmv_pkg;

    // Phase accumulator and sine table geometry.
    localparam int PHASE_BITS    = 24;
    localparam int SINE_LUT_BITS = 10;
    localparam int QUARTER_SIZE  = 1 << (SINE_LUT_BITS - 2);

    // The increment product is turns * 2^28; it is moved to PHASE_BITS by a shift.
    localparam int INC_SHL   = (PHASE_BITS >= 28) ? PHASE_BITS - 28 : 0;
    localparam int INC_SHR   = (PHASE_BITS < 28) ? 28 - PHASE_BITS : 0;
    localparam int MOD_SHIFT = 47 - PHASE_BITS;

    localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
    localparam logic [31:0] GAIN_POINT3_Q15 = 32'd9830;
    // ceil(2^21 / 3): exact truncating division by three for magnitudes below 2^21.
    localparam logic [31:0] DIV3_RECIP      = 32'd699051;
    localparam int          DIV3_SHIFT      = 21;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_INC  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATIOS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVELS_LO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVELS_HI = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALGORITHM = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY  = 3'd6;

    localparam logic [31:0] RATIOS_RESET    = 32'h4030_2010;
    localparam logic [31:0] LEVELS_LO_RESET = 32'h8000_8000;
    localparam logic [31:0] LEVELS_HI_RESET = 32'h4000_4000;

    // Routing topologies.
    localparam logic [2:0] ALG_ADDITIVE        = 3'd0;
    localparam logic [2:0] ALG_STACK           = 3'd1;
    localparam logic [2:0] ALG_TWO_STACKS      = 3'd2;
    localparam logic [2:0] ALG_MERGE_STACK     = 3'd3;
    localparam logic [2:0] ALG_ONE_TO_THREE    = 3'd4;
    localparam logic [2:0] ALG_PAIR_PLUS_TWO   = 3'd5;
    localparam logic [2:0] ALG_THREE_PLUS_ONE  = 3'd6;
    localparam logic [2:0] ALG_THREE_TO_ONE    = 3'd7;

    // Source kinds for a modulation input or the final mix.
    localparam logic [2:0] SRC_NONE    = 3'd0;
    localparam logic [2:0] SRC_FB      = 3'd1;
    localparam logic [2:0] SRC_FB_S    = 3'd2;
    localparam logic [2:0] SRC_S       = 3'd3;
    localparam logic [2:0] SRC_HALF    = 3'd4;
    localparam logic [2:0] SRC_DIV3    = 3'd5;
    localparam logic [2:0] SRC_QUARTER = 3'd6;

    // Datapath actions.
    localparam logic [4:0] ACT_IDLE     = 5'd0;
    localparam logic [4:0] ACT_LOAD     = 5'd1;
    localparam logic [4:0] ACT_PH_MUL   = 5'd2;
    localparam logic [4:0] ACT_PH_WB    = 5'd3;
    localparam logic [4:0] ACT_FB_MUL   = 5'd4;
    localparam logic [4:0] ACT_FB_WB    = 5'd5;
    localparam logic [4:0] ACT_SRC_MUL  = 5'd6;
    localparam logic [4:0] ACT_SRC_WB   = 5'd7;
    localparam logic [4:0] ACT_MOD_MUL  = 5'd8;
    localparam logic [4:0] ACT_MOD_WB   = 5'd9;
    localparam logic [4:0] ACT_SIN_MUL  = 5'd10;
    localparam logic [4:0] ACT_SIN_WB   = 5'd11;
    localparam logic [4:0] ACT_LVL_MUL  = 5'd12;
    localparam logic [4:0] ACT_LVL_WB   = 5'd13;
    localparam logic [4:0] ACT_VEL_MUL  = 5'd14;
    localparam logic [4:0] ACT_VEL_WB   = 5'd15;
    localparam logic [4:0] ACT_GAIN_MUL = 5'd16;
    localparam logic [4:0] ACT_OUT      = 5'd17;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] kind;
        logic [1:0] src;
        logic       level;
    } op_task_t;

    typedef op_task_t [3:0] program_t;

    typedef struct packed {
        logic [4:0] action;
        logic [1:0] op;
        logic [2:0] kind;
        logic [1:0] src;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] algorithm;
        logic       out_free;
    } dp_status_t;

    typedef logic [15:0] qsine_t [0:QUARTER_SIZE];

    function automatic qsine_t build_quarter_sine();
        qsine_t      tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] y;
        for (int k = 0; k <= QUARTER_SIZE; k++) begin
            x  = 64'(k) << (32 - SINE_LUT_BITS);
            x2 = (x * x) >> 30;
            t  = 64'd85569306 - ((64'd5026996 * x2) >> 30);
            t  = 64'd693598670 - ((t * x2) >> 30);
            t  = 64'd1686629713 - ((t * x2) >> 30);
            y  = (t * x) >> 30;
            y  = (y + 64'd16384) >> 15;
            if (y > 64'd32767) begin
                y = 64'd32767;
            end
            tbl[k] = y[15:0];
        end
        return tbl;
    endfunction

    localparam qsine_t QUARTER_SINE = build_quarter_sine();

    function automatic op_task_t mk_task(input logic [1:0] op, input logic [2:0] kind,
                                         input logic [1:0] src, input logic level);
        op_task_t t;
        t.op    = op;
        t.kind  = kind;
        t.src   = src;
        t.level = level;
        return t;
    endfunction

    // Operator evaluation order for each topology; entry 0 runs first.
    function automatic op_task_t alg_task(input logic [2:0] alg, input logic [1:0] step);
        program_t p;
        case (alg)
            ALG_ADDITIVE: begin
                p = {mk_task(2'd3, SRC_NONE, 2'd0, 1'b1), mk_task(2'd2, SRC_NONE, 2'd0, 1'b1),
                     mk_task(2'd1, SRC_NONE, 2'd0, 1'b1), mk_task(2'd0, SRC_FB, 2'd0, 1'b1)};
            end
            ALG_STACK: begin
                p = {mk_task(2'd0, SRC_FB_S, 2'd1, 1'b0), mk_task(2'd1, SRC_S, 2'd2, 1'b0),
                     mk_task(2'd2, SRC_S, 2'd3, 1'b0), mk_task(2'd3, SRC_NONE, 2'd0, 1'b0)};
            end
            ALG_TWO_STACKS: begin
                p = {mk_task(2'd2, SRC_S, 2'd3, 1'b1), mk_task(2'd3, SRC_NONE, 2'd0, 1'b0),
                     mk_task(2'd0, SRC_FB_S, 2'd1, 1'b1), mk_task(2'd1, SRC_NONE, 2'd0, 1'b0)};
            end
            ALG_MERGE_STACK: begin
                p = {mk_task(2'd3, SRC_S, 2'd2, 1'b0), mk_task(2'd2, SRC_HALF, 2'd1, 1'b0),
                     mk_task(2'd0, SRC_FB, 2'd0, 1'b1), mk_task(2'd1, SRC_NONE, 2'd0, 1'b1)};
            end
            ALG_ONE_TO_THREE: begin
                p = {mk_task(2'd3, SRC_S, 2'd0, 1'b1), mk_task(2'd2, SRC_S, 2'd0, 1'b1),
                     mk_task(2'd1, SRC_S, 2'd0, 1'b1), mk_task(2'd0, SRC_FB, 2'd0, 1'b0)};
            end
            ALG_PAIR_PLUS_TWO: begin
                p = {mk_task(2'd3, SRC_NONE, 2'd0, 1'b1), mk_task(2'd2, SRC_NONE, 2'd0, 1'b1),
                     mk_task(2'd0, SRC_FB_S, 2'd1, 1'b1), mk_task(2'd1, SRC_NONE, 2'd0, 1'b0)};
            end
            ALG_THREE_PLUS_ONE: begin
                p = {mk_task(2'd3, SRC_NONE, 2'd0, 1'b1), mk_task(2'd0, SRC_FB_S, 2'd1, 1'b1),
                     mk_task(2'd1, SRC_S, 2'd2, 1'b0), mk_task(2'd2, SRC_NONE, 2'd0, 1'b0)};
            end
            default: begin
                p = {mk_task(2'd3, SRC_DIV3, 2'd3, 1'b0), mk_task(2'd2, SRC_NONE, 2'd0, 1'b1),
                     mk_task(2'd1, SRC_NONE, 2'd0, 1'b1), mk_task(2'd0, SRC_FB, 2'd0, 1'b1)};
            end
        endcase
        return p[step];
    endfunction

    // Final mix of each topology.
    function automatic op_task_t mix_task(input logic [2:0] alg);
        op_task_t t;
        case (alg)
            ALG_ADDITIVE:       t = mk_task(2'd0, SRC_QUARTER, 2'd0, 1'b0);
            ALG_STACK:          t = mk_task(2'd0, SRC_S, 2'd0, 1'b0);
            ALG_TWO_STACKS:     t = mk_task(2'd0, SRC_HALF, 2'd2, 1'b0);
            ALG_MERGE_STACK:    t = mk_task(2'd0, SRC_S, 2'd3, 1'b0);
            ALG_ONE_TO_THREE:   t = mk_task(2'd0, SRC_DIV3, 2'd0, 1'b0);
            ALG_PAIR_PLUS_TWO:  t = mk_task(2'd0, SRC_DIV3, 2'd1, 1'b0);
            ALG_THREE_PLUS_ONE: t = mk_task(2'd0, SRC_HALF, 2'd3, 1'b0);
            default:            t = mk_task(2'd0, SRC_S, 2'd3, 1'b0);
        endcase
        return t;
    endfunction

    function automatic logic [15:0] level_pick(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [1:0] idx);
        logic [31:0] pair;
        pair = idx[1] ? hi : lo;
        return idx[0] ? pair[31:16] : pair[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/four_operator_fm_voice.sv -----
// Four-operator FM voice. Every input word is one sample tick carrying the four
// operator envelope levels; every tick yields exactly one signed Q1.15 output word.
// On a tick the four phase accumulators (turns, 24 bits) advance by the base
// increment times each operator's Q4.4 ratio, and the operators are evaluated in
// the order the selected algorithm needs, with phase modulation from earlier
// operators and self feedback on operator 0. The mix is then scaled by velocity
// and by 0.3 and saturated. All products go through one shared 32 x 32 multiplier
// that a state machine sequences, one multiply and one writeback per product, so
// the time from acceptance to a ready output word depends on how many operators
// of the algorithm carry an output level, and on the output register being free.
// The next word is accepted as soon as the sequence has handed its result to the
// output register, even while that result still waits to be taken.
// Configuration registers are written through the plain write port and must only
// be changed while the voice is idle; they take effect on the next tick.
module four_operator_fm_voice
    import fmv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input words: env_op0 [15:0], env_op1 [31:16], env_op2 [47:32], env_op3 [63:48].
    input  logic [63:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Output words: sample_out [15:0].
    output logic [15:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Register write port; indexes beyond the register list are ignored.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller walks the per-algorithm operator program and issues one datapath
    // action per cycle, except while waiting for an input word or a free output.
    fmv_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the phases, the operator values, the sine table, the
    // shared multiplier and the output register.
    fmv_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .env_in    (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

// ----- hdl/fmv_datapath.sv -----
module fmv_datapath
    import fmv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [63:0]           env_in,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  m_tready,
    output logic                  out_valid,
    output logic [15:0]           out_data
);

    logic [22:0] base_inc_reg;
    logic [31:0] ratios_reg;
    logic [31:0] levels_lo_reg;
    logic [31:0] levels_hi_reg;
    logic [2:0]  algorithm_reg;
    logic [15:0] feedback_reg;
    logic [15:0] velocity_reg;

    logic [PHASE_BITS-1:0] phase_reg [4];
    logic [PHASE_BITS-1:0] phm_reg;
    logic signed [15:0]    last_op0_reg;
    logic [15:0]           env_reg [4];
    logic signed [17:0]    o_reg [4];
    logic signed [19:0]    fb_reg;
    logic signed [19:0]    src_reg;
    logic signed [20:0]    t_reg;
    logic signed [63:0]    prod_reg;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_s15;
    logic signed [63:0] prod_s16;
    logic signed [63:0] prod_mod;
    logic [63:0]        inc_full;
    logic signed [17:0] scaled_q;
    logic signed [17:0] fb_q;
    logic [17:0]        div3_q;
    logic signed [18:0] sum_half;
    logic signed [19:0] sum_all;
    logic signed [19:0] sum_div3;
    logic [19:0]        div3_mag;
    logic signed [19:0] src_value;
    logic [SINE_LUT_BITS-1:0] lut_idx;
    logic [SINE_LUT_BITS-3:0] lut_off;
    logic [SINE_LUT_BITS-2:0] tab_idx;
    logic signed [15:0] sine_val;

    always_comb begin
        sum_half = 19'(o_reg[0]) + 19'(o_reg[cmd.src]);
        sum_all  = 20'(o_reg[0]) + 20'(o_reg[1]) + 20'(o_reg[2]) + 20'(o_reg[3]);
        sum_div3 = sum_all - 20'(o_reg[cmd.src]);
        div3_mag = (sum_div3 < 0) ? 20'(-sum_div3) : 20'(sum_div3);

        lut_idx  = phm_reg[PHASE_BITS-1 -: SINE_LUT_BITS];
        lut_off  = lut_idx[SINE_LUT_BITS-3:0];
        tab_idx  = lut_idx[SINE_LUT_BITS-2] ?
                   ((SINE_LUT_BITS-1)'(QUARTER_SIZE) - {1'b0, lut_off}) : {1'b0, lut_off};
        sine_val = lut_idx[SINE_LUT_BITS-1] ? -$signed(QUARTER_SINE[tab_idx])
                                            : $signed(QUARTER_SINE[tab_idx]);
    end

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.action)
            ACT_PH_MUL: begin
                mul_a = 32'(base_inc_reg);
                mul_b = 32'(ratios_reg[8*cmd.op +: 8]);
            end
            ACT_FB_MUL: begin
                mul_a = 32'(last_op0_reg);
                mul_b = 32'(feedback_reg);
            end
            ACT_SRC_MUL: begin
                if (cmd.kind == SRC_DIV3) begin
                    mul_a = 32'(div3_mag);
                    mul_b = DIV3_RECIP;
                end else begin
                    mul_a = 32'(o_reg[cmd.src]);
                    mul_b = 32'(level_pick(levels_lo_reg, levels_hi_reg, cmd.src));
                end
            end
            ACT_MOD_MUL: begin
                mul_a = 32'(src_reg);
                mul_b = INV_TWO_PI_Q32;
            end
            ACT_SIN_MUL: begin
                mul_a = 32'(sine_val);
                mul_b = 32'(env_reg[cmd.op]);
            end
            ACT_LVL_MUL: begin
                mul_a = 32'(o_reg[cmd.op]);
                mul_b = 32'(level_pick(levels_lo_reg, levels_hi_reg, cmd.op));
            end
            ACT_VEL_MUL: begin
                mul_a = 32'(src_reg);
                mul_b = 32'(velocity_reg);
            end
            ACT_GAIN_MUL: begin
                mul_a = 32'(t_reg);
                mul_b = GAIN_POINT3_Q15;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod_s15 = prod_reg >>> 15;
        prod_s16 = prod_reg >>> 16;
        prod_mod = prod_reg >>> MOD_SHIFT;
        inc_full = (64'(prod_reg) << INC_SHL) >> INC_SHR;
        scaled_q = prod_s15[17:0];
        fb_q     = prod_s15[17:0];
        div3_q   = prod_reg[DIV3_SHIFT +: 18];
        case (cmd.kind)
            SRC_NONE:    src_value = '0;
            SRC_FB:      src_value = fb_reg;
            SRC_FB_S:    src_value = fb_reg + 20'(scaled_q);
            SRC_S:       src_value = 20'(scaled_q);
            SRC_HALF:    src_value = 20'(sum_half >>> 1);
            SRC_QUARTER: src_value = sum_all >>> 2;
            SRC_DIV3: begin
                src_value = (sum_div3 < 0) ? -$signed({2'b00, div3_q})
                                           : $signed({2'b00, div3_q});
            end
            default:     src_value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_inc_reg  <= '0;
            ratios_reg    <= RATIOS_RESET;
            levels_lo_reg <= LEVELS_LO_RESET;
            levels_hi_reg <= LEVELS_HI_RESET;
            algorithm_reg <= ALG_ADDITIVE;
            feedback_reg  <= '0;
            velocity_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_INC:  base_inc_reg  <= cfg_wdata[22:0];
                REG_RATIOS:    ratios_reg    <= cfg_wdata;
                REG_LEVELS_LO: levels_lo_reg <= cfg_wdata;
                REG_LEVELS_HI: levels_hi_reg <= cfg_wdata;
                REG_ALGORITHM: algorithm_reg <= cfg_wdata[2:0];
                REG_FEEDBACK:  feedback_reg  <= cfg_wdata[15:0];
                REG_VELOCITY:  velocity_reg  <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                phase_reg[i] <= '0;
            end
            last_op0_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.action == ACT_PH_WB) begin
                phase_reg[cmd.op] <= phase_reg[cmd.op] + inc_full[PHASE_BITS-1:0];
            end
            if (cmd.action == ACT_OUT) begin
                last_op0_reg  <= sat16(64'(o_reg[0]));
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        // The product is held while no action runs, so the gain product survives
        // a wait for the output register.
        if (cmd.action != ACT_IDLE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.action)
            ACT_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                    env_reg[i] <= env_in[16*i +: 16];
                    o_reg[i]   <= '0;
                end
            end
            ACT_FB_WB:  fb_reg <= (20'(fb_q) <<< 1) + 20'(fb_q);
            ACT_SRC_WB: src_reg <= src_value;
            ACT_MOD_WB: phm_reg <= phase_reg[cmd.op] + prod_mod[PHASE_BITS-1:0];
            ACT_SIN_WB: o_reg[cmd.op] <= prod_s16[17:0];
            ACT_LVL_WB: o_reg[cmd.op] <= prod_s15[17:0];
            ACT_VEL_WB: t_reg <= prod_s15[20:0];
            ACT_OUT:    out_data_reg <= sat16(prod_s15);
            default: begin
            end
        endcase
    end

    assign status.algorithm = algorithm_reg;
    assign status.out_free  = !out_valid_reg || m_tready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

// ----- hdl/fmv_controller.sv -----
module fmv_controller
    import fmv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_PH_MUL   = 5'd1;
    localparam logic [4:0] S_PH_WB    = 5'd2;
    localparam logic [4:0] S_FB_MUL   = 5'd3;
    localparam logic [4:0] S_FB_WB    = 5'd4;
    localparam logic [4:0] S_SRC_MUL  = 5'd5;
    localparam logic [4:0] S_SRC_WB   = 5'd6;
    localparam logic [4:0] S_MOD_MUL  = 5'd7;
    localparam logic [4:0] S_MOD_WB   = 5'd8;
    localparam logic [4:0] S_SIN_MUL  = 5'd9;
    localparam logic [4:0] S_SIN_WB   = 5'd10;
    localparam logic [4:0] S_LVL_MUL  = 5'd11;
    localparam logic [4:0] S_LVL_WB   = 5'd12;
    localparam logic [4:0] S_MIX_MUL  = 5'd13;
    localparam logic [4:0] S_MIX_WB   = 5'd14;
    localparam logic [4:0] S_VEL_MUL  = 5'd15;
    localparam logic [4:0] S_VEL_WB   = 5'd16;
    localparam logic [4:0] S_GAIN_MUL = 5'd17;
    localparam logic [4:0] S_OUT      = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    op_task_t   cur_task;
    op_task_t   mix;

    always_comb begin
        cur_task   = alg_task(status.algorithm, step_reg);
        mix        = mix_task(status.algorithm);
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd.action = ACT_IDLE;
        cmd.op     = cur_task.op;
        cmd.kind   = cur_task.kind;
        cmd.src    = cur_task.src;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.action = ACT_LOAD;
                    step_next  = 2'd0;
                    state_next = S_PH_MUL;
                end
            end
            S_PH_MUL: begin
                cmd.action = ACT_PH_MUL;
                cmd.op     = step_reg;
                state_next = S_PH_WB;
            end
            S_PH_WB: begin
                cmd.action = ACT_PH_WB;
                cmd.op     = step_reg;
                step_next  = step_reg + 2'd1;
                state_next = (step_reg == 2'd3) ? S_FB_MUL : S_PH_MUL;
            end
            S_FB_MUL: begin
                cmd.action = ACT_FB_MUL;
                state_next = S_FB_WB;
            end
            S_FB_WB: begin
                cmd.action = ACT_FB_WB;
                state_next = S_SRC_MUL;
            end
            S_SRC_MUL: begin
                cmd.action = ACT_SRC_MUL;
                state_next = S_SRC_WB;
            end
            S_SRC_WB: begin
                cmd.action = ACT_SRC_WB;
                state_next = S_MOD_MUL;
            end
            S_MOD_MUL: begin
                cmd.action = ACT_MOD_MUL;
                state_next = S_MOD_WB;
            end
            S_MOD_WB: begin
                cmd.action = ACT_MOD_WB;
                state_next = S_SIN_MUL;
            end
            S_SIN_MUL: begin
                cmd.action = ACT_SIN_MUL;
                state_next = S_SIN_WB;
            end
            S_SIN_WB: begin
                cmd.action = ACT_SIN_WB;
                if (cur_task.level) begin
                    state_next = S_LVL_MUL;
                end else begin
                    step_next  = step_reg + 2'd1;
                    state_next = (step_reg == 2'd3) ? S_MIX_MUL : S_SRC_MUL;
                end
            end
            S_LVL_MUL: begin
                cmd.action = ACT_LVL_MUL;
                state_next = S_LVL_WB;
            end
            S_LVL_WB: begin
                cmd.action = ACT_LVL_WB;
                step_next  = step_reg + 2'd1;
                state_next = (step_reg == 2'd3) ? S_MIX_MUL : S_SRC_MUL;
            end
            S_MIX_MUL: begin
                cmd.action = ACT_SRC_MUL;
                cmd.kind   = mix.kind;
                cmd.src    = mix.src;
                state_next = S_MIX_WB;
            end
            S_MIX_WB: begin
                cmd.action = ACT_SRC_WB;
                cmd.kind   = mix.kind;
                cmd.src    = mix.src;
                state_next = S_VEL_MUL;
            end
            S_VEL_MUL: begin
                cmd.action = ACT_VEL_MUL;
                state_next = S_VEL_WB;
            end
            S_VEL_WB: begin
                cmd.action = ACT_VEL_WB;
                state_next = S_GAIN_MUL;
            end
            S_GAIN_MUL: begin
                cmd.action = ACT_GAIN_MUL;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.action = ACT_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- sim/four_operator_fm_voice_tb.sv -----
module four_operator_fm_voice_tb;
    import fmv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk;
    logic                  aresetn;
    logic [63:0]           s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;

    four_operator_fm_voice dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // The run is ended by force if it goes on far longer than the slowest correct
    // run could: about 500 ticks, plus sender gaps, receiver stalls and one long
    // hold-off.
    localparam int CYCLE_LIMIT = 600000;
    localparam longint unsigned PH_MASK = (64'd1 << PHASE_BITS) - 1;

    // Our own copy of the voice: registers, phase accumulators, feedback memory.
    logic [22:0] base_inc_r;
    logic [31:0] ratios_r;
    logic [31:0] levels_lo_r;
    logic [31:0] levels_hi_r;
    logic [2:0]  alg_r;
    logic [15:0] fb_amt_r;
    logic [15:0] velocity_r;
    longint unsigned phase_acc [4];
    longint          op0_memory;
    longint          sine_quarter [QUARTER_SIZE + 1];

    logic [63:0] pending_words [$];
    logic [15:0] expected_samples [$];
    int          mismatches;
    int          cycle_count;
    bit          word_taken;
    bit          sender_hold;
    int          burst_left;
    int          gap_left;
    int          hold_off_cycles;
    int          rx_run;
    bit          rx_level;

    // Quarter-wave table from the odd polynomial in Q30, rounded half up.
    function automatic void fill_sine_quarter();
        longint unsigned x, x2, t, y;
        for (int k = 0; k <= QUARTER_SIZE; k++) begin
            x  = longint'(k) << (32 - SINE_LUT_BITS);
            x2 = (x * x) >> 30;
            t  = 64'd85569306 - ((64'd5026996 * x2) >> 30);
            t  = 64'd693598670 - ((t * x2) >> 30);
            t  = 64'd1686629713 - ((t * x2) >> 30);
            y  = (((t * x) >> 30) + 64'd16384) >> 15;
            sine_quarter[k] = (y > 32767) ? 32767 : longint'(y);
        end
    endfunction

    function automatic longint sine_lookup(longint unsigned ph);
        int idx, quad, offs;
        longint v;
        idx  = int'((ph >> (PHASE_BITS - SINE_LUT_BITS)) & ((1 << SINE_LUT_BITS) - 1));
        quad = (idx >> (SINE_LUT_BITS - 2)) & 3;
        offs = idx & (QUARTER_SIZE - 1);
        v = quad[0] ? sine_quarter[QUARTER_SIZE - offs] : sine_quarter[offs];
        return quad[1] ? -v : v;
    endfunction

    // Radians in Q1.15 become a phase offset in turns; >>> on a signed longint floors.
    function automatic longint unsigned phase_mod(longint unsigned ph, longint rad);
        longint offs;
        offs = (rad * longint'(INV_TWO_PI_Q32)) >>> MOD_SHIFT;
        return (ph + longint'(offs)) & PH_MASK;
    endfunction

    function automatic longint apply_level(longint v, int i);
        logic [31:0] pair;
        longint lvl;
        pair = (i < 2) ? levels_lo_r : levels_hi_r;
        lvl  = (i % 2) ? longint'(pair[31:16]) : longint'(pair[15:0]);
        return (v * lvl) >>> 15;
    endfunction

    function automatic longint op_eval(int i, longint unsigned ph, longint env, bit lvl);
        longint v;
        v = (sine_lookup(ph) * env) >>> 16;
        return lvl ? apply_level(v, i) : v;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // One sample tick: advance the accumulators, run the topology, scale the mix.
    function automatic logic [15:0] voice_tick(logic [63:0] word);
        longint env [4];
        longint unsigned p [4];
        longint unsigned inc;
        longint o0, o1, o2, o3, mix, fb, m, t;
        o0 = 0; o1 = 0; o2 = 0; o3 = 0;
        for (int i = 0; i < 4; i++) begin
            inc = longint'(base_inc_r) * longint'(ratios_r[i*8 +: 8]);
            inc = (inc << INC_SHL) >> INC_SHR;
            env[i] = longint'(word[i*16 +: 16]);
            phase_acc[i] = (phase_acc[i] + inc) & PH_MASK;
            p[i] = phase_acc[i];
        end
        fb = ((op0_memory * longint'(fb_amt_r)) >>> 15) * 3;
        case (alg_r)
            ALG_ADDITIVE: begin
                o0 = op_eval(0, phase_mod(p[0], fb), env[0], 1);
                o1 = op_eval(1, p[1], env[1], 1);
                o2 = op_eval(2, p[2], env[2], 1);
                o3 = op_eval(3, p[3], env[3], 1);
                mix = (o0 + o1 + o2 + o3) >>> 2;
            end
            ALG_STACK: begin
                o3 = op_eval(3, p[3], env[3], 0);
                o2 = op_eval(2, phase_mod(p[2], apply_level(o3, 3)), env[2], 0);
                o1 = op_eval(1, phase_mod(p[1], apply_level(o2, 2)), env[1], 0);
                o0 = op_eval(0, phase_mod(p[0], fb + apply_level(o1, 1)), env[0], 0);
                mix = apply_level(o0, 0);
            end
            ALG_TWO_STACKS: begin
                o1 = op_eval(1, p[1], env[1], 0);
                o0 = op_eval(0, phase_mod(p[0], fb + apply_level(o1, 1)), env[0], 1);
                o3 = op_eval(3, p[3], env[3], 0);
                o2 = op_eval(2, phase_mod(p[2], apply_level(o3, 3)), env[2], 1);
                mix = (o0 + o2) >>> 1;
            end
            ALG_MERGE_STACK: begin
                o1 = op_eval(1, p[1], env[1], 1);
                o0 = op_eval(0, phase_mod(p[0], fb), env[0], 1);
                o2 = op_eval(2, phase_mod(p[2], (o0 + o1) >>> 1), env[2], 0);
                o3 = op_eval(3, phase_mod(p[3], apply_level(o2, 2)), env[3], 0);
                mix = apply_level(o3, 3);
            end
            ALG_ONE_TO_THREE: begin
                o0 = op_eval(0, phase_mod(p[0], fb), env[0], 0);
                m  = apply_level(o0, 0);
                o1 = op_eval(1, phase_mod(p[1], m), env[1], 1);
                o2 = op_eval(2, phase_mod(p[2], m), env[2], 1);
                o3 = op_eval(3, phase_mod(p[3], m), env[3], 1);
                mix = (o1 + o2 + o3) / 3;
            end
            ALG_PAIR_PLUS_TWO: begin
                o1 = op_eval(1, p[1], env[1], 0);
                o0 = op_eval(0, phase_mod(p[0], fb + apply_level(o1, 1)), env[0], 1);
                o2 = op_eval(2, p[2], env[2], 1);
                o3 = op_eval(3, p[3], env[3], 1);
                mix = (o0 + o2 + o3) / 3;
            end
            ALG_THREE_PLUS_ONE: begin
                o2 = op_eval(2, p[2], env[2], 0);
                o1 = op_eval(1, phase_mod(p[1], apply_level(o2, 2)), env[1], 0);
                o0 = op_eval(0, phase_mod(p[0], fb + apply_level(o1, 1)), env[0], 1);
                o3 = op_eval(3, p[3], env[3], 1);
                mix = (o0 + o3) >>> 1;
            end
            default: begin
                o0 = op_eval(0, phase_mod(p[0], fb), env[0], 1);
                o1 = op_eval(1, p[1], env[1], 1);
                o2 = op_eval(2, p[2], env[2], 1);
                m  = (o0 + o1 + o2) / 3;
                o3 = op_eval(3, phase_mod(p[3], m), env[3], 0);
                mix = apply_level(o3, 3);
            end
        endcase
        // Operator 0 is clipped to 16 bits before it is kept for feedback.
        op0_memory = clip16(o0);
        t = (mix * longint'(velocity_r)) >>> 15;
        t = clip16((t * longint'(GAIN_POINT3_Q15)) >>> 15);
        return t[15:0];
    endfunction

    // Writes one register on the port and in our copy; only called while idle.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_BASE_INC:  base_inc_r  = val[22:0];
            REG_RATIOS:    ratios_r    = val;
            REG_LEVELS_LO: levels_lo_r = val;
            REG_LEVELS_HI: levels_hi_r = val;
            REG_ALGORITHM: alg_r       = val[2:0];
            REG_FEEDBACK:  fb_amt_r    = val[15:0];
            REG_VELOCITY:  velocity_r  = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued word has gone in and every sample has come back,
    // then lets the block settle before registers are touched.
    task automatic drain();
        while (pending_words.size() != 0 || expected_samples.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
    endtask

    // Envelope words lean on the extremes now and then.
    function automatic logic [63:0] random_envelopes();
        logic [63:0] w;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 7))
                0:       w[i*16 +: 16] = 16'h0000;
                1:       w[i*16 +: 16] = 16'hffff;
                default: w[i*16 +: 16] = 16'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic logic [31:0] pick_gain(logic [31:0] nominal_max);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return nominal_max;
            2:       return 32'hffff;
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Input side: every accepted word is run through our copy at once, so the
    // expected sample is queued before the block can possibly return it.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_samples.push_back(voice_tick(s_tdata));
            word_taken = 1'b1;
        end
    end

    // Sender: bursts of random length separated by random gaps. A new word is
    // put up only when the previous one has been taken or none is offered.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || word_taken)) begin
            word_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (!sender_hold && pending_words.size() != 0) begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stretches of steady ready or steady stall of random length, and a
    // long hold-off when the stimulus asks for one.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_tready <= 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
            m_tready <= rx_level;
        end else begin
            rx_run   = $urandom_range(1, 40);
            rx_level = ($urandom_range(0, 2) != 0);
            m_tready <= rx_level;
        end
    end

    // Output side: each sample is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output word %h", m_tdata);
                end
            end else begin
                logic [15:0] want;
                want = expected_samples.pop_front();
                if (m_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("sample_out mismatch: expected %h, got %h", want, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        s_tdata         = '0;
        s_tvalid        = 1'b0;
        m_tready        = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        aresetn         = 1'b0;
        mismatches      = 0;
        cycle_count     = 0;
        word_taken      = 1'b0;
        sender_hold     = 1'b0;
        burst_left      = 0;
        gap_left        = 0;
        hold_off_cycles = 0;
        rx_run          = 0;
        rx_level        = 1'b1;
        base_inc_r      = '0;
        ratios_r        = RATIOS_RESET;
        levels_lo_r     = LEVELS_LO_RESET;
        levels_hi_r     = LEVELS_HI_RESET;
        alg_r           = ALG_ADDITIVE;
        fb_amt_r        = '0;
        velocity_r      = '0;
        op0_memory      = 0;
        for (int i = 0; i < 4; i++) phase_acc[i] = 0;
        fill_sine_quarter();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. First a few ticks at the reset settings, where zero
        // velocity silences everything, then full velocity and feedback and the extremes.
        pending_words.push_back(64'h0);
        pending_words.push_back('1);
        drain();
        // A write to the unused index must leave every register alone.
        write_reg(3'd7, 32'hffff_ffff);
        write_reg(REG_VELOCITY, 32'd32768);
        write_reg(REG_BASE_INC, 32'h7f_ffff);
        write_reg(REG_FEEDBACK, 32'd32768);
        pending_words.push_back(64'h0);
        pending_words.push_back('1);
        pending_words.push_back(64'hffff_0000_ffff_0000);
        pending_words.push_back(64'h0000_ffff_0000_ffff);
        pending_words.push_back(64'h8000_8000_8000_8000);
        pending_words.push_back('1);
        drain();
        // Out-of-range gains are used as written, which drives the output into
        // saturation; with maximum feedback the stored operator 0 clips too.
        write_reg(REG_LEVELS_LO, 32'hffff_ffff);
        write_reg(REG_LEVELS_HI, 32'hffff_ffff);
        write_reg(REG_VELOCITY, 32'hffff);
        write_reg(REG_FEEDBACK, 32'hffff);
        write_reg(REG_RATIOS, 32'hffff_ffff);
        for (int a = 0; a < 8; a++) begin
            write_reg(REG_ALGORITHM, 32'(a));
            pending_words.push_back('1);
            pending_words.push_back('1);
            drain();
        end
        write_reg(REG_RATIOS, 32'h0);
        pending_words.push_back('1);
        drain();

        // Random part: every topology with its own random settings, several
        // dozen ticks each. Each phase ends with the sender paused until every
        // expected sample has come back.
        for (int ph = 0; ph < 16; ph++) begin
            write_reg(REG_ALGORITHM, 32'(ph % 8));
            write_reg(REG_BASE_INC, (ph % 5 == 0) ? 32'h7f_ffff
                                                  : 32'($urandom_range(0, 32'h7f_ffff)));
            write_reg(REG_RATIOS, (ph % 7 == 3) ? 32'h0 : $urandom);
            write_reg(REG_LEVELS_LO, {16'(pick_gain(32768)), 16'(pick_gain(32768))});
            write_reg(REG_LEVELS_HI, {16'(pick_gain(32768)), 16'(pick_gain(32768))});
            write_reg(REG_FEEDBACK, pick_gain(32768));
            write_reg(REG_VELOCITY, (ph % 4 == 0) ? 32'd32768 : pick_gain(32768));
            for (int n = 0; n < 30; n++) begin
                pending_words.push_back(random_envelopes());
            end
            // Once, the receiver stays off long enough that the block fills up
            // and has to stall its input while words keep being offered.
            if (ph == 5) begin
                hold_off_cycles = 600;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
